// File: design/tmd_pkg.sv
// Shared types and op codes for the tour move delta engine.
`default_nettype none
package tmd_pkg;

    typedef enum logic [2:0] {
        OP_WR_TIME  = 3'd0,
        OP_WR_DEPOT = 3'd1,
        OP_WR_TOUR  = 3'd2,
        OP_REVERSE  = 3'd3,
        OP_SWAP     = 3'd4,
        OP_ROTATE   = 3'd5
    } op_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [5:0]  pos_i;
        logic [5:0]  pos_j;
        logic [5:0]  pos_k;
        logic [5:0]  from_node;
        logic [5:0]  to_node;
        logic [31:0] time_value;
    } in_item_t;

    typedef struct packed {
        logic signed [39:0] delta;
        logic               bad_request;
    } out_item_t;

    // Term kinds of one delta step: edge, depot, or nothing.
    typedef enum logic [1:0] {
        TK_NONE  = 2'd0,
        TK_EDGE  = 2'd1,
        TK_DEPOT = 2'd2
    } term_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_TOUR  = 3'd1,
        ST_NODE  = 3'd2,
        ST_TIME  = 3'd3,
        ST_ACC   = 3'd4,
        ST_OUT   = 3'd5
    } state_t;

    localparam int POS_BITS = 6;
    localparam int MAX_POS  = 64;
    localparam int DELTA_BITS = 40;

endpackage
`default_nettype wire

// File: design/tour_move_delta_engine.sv
// Top level of the tour move delta engine: stores, term sequencer, accumulator.
//
//   channel | direction | payload    | handshake
//   --------+-----------+------------+-----------------------------------
//   in      | input     | in_item_t  | in_valid / in_stall (accept: v & !s)
//   out     | output    | out_item_t | out_valid / out_stall
//   cfg     | input     | tour_length| cfg_wr_en / cfg_wr_data
//
// A write, a bad request or an unused op goes from accept to the OUT state, which
// loads the output register. A move is walked as a list of N signed terms; each
// term passes through TOUR, NODE, TIME and ACC (tour read for two positions, then
// the time read). N is 2*(j-i)+4 for reverse (up to 130), 6 or 8 for swap and 6
// for rotate. The reads go in turn since each store has a single read port.
// Reset clears control only; stores hold garbage until written.
// The result sits in an output register; the next item is taken the cycle
// after it has left.
`default_nettype none
module tour_move_delta_engine
    import tmd_pkg::*;
#(
    parameter int NODE_COUNT = 64,
    parameter int TIME_BITS  = 32
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_item_t  in_item,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_item_t      out_item,
    input  wire logic      cfg_wr_en,
    input  wire logic [6:0] cfg_wr_data
);

    localparam int NB = $clog2(NODE_COUNT);
    localparam int TA = 2 * NB;
    localparam int SB = TIME_BITS + 2;   // signed term width

    state_t state_reg, state_next;
    in_item_t req_reg;
    logic [6:0] len_reg;
    logic [7:0] step_reg, step_next;   // term index
    logic [7:0] nsteps_reg;
    logic signed [63:0] acc_reg, acc_next;
    logic bad_reg;
    logic out_valid_reg;
    out_item_t out_reg;

    // Per-term decode: kind, sign, positions of a and b.
    term_kind_t  tk;
    logic        tneg;
    logic [5:0]  pa, pb;
    logic [NB-1:0] na_reg, nb_reg;

    logic [5:0]  tour_rd_addr;
    logic [5:0]  tour_rd_data;
    logic [TA-1:0] time_rd_addr;
    logic [TIME_BITS-1:0] time_rd_data, depot_rd_data;
    logic        tour_we, time_we, depot_we;
    logic        phase_reg;   // 0: read a, 1: read b

    logic [5:0] i, j, k;
    logic [6:0] len;
    logic       accept;

    assign i = req_reg.pos_i;
    assign j = req_reg.pos_j;
    assign k = req_reg.pos_k;
    assign len = len_reg;
    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE) || out_valid_reg;

    // Config register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_reg <= 7'd2;
        else if (cfg_wr_en)
            len_reg <= cfg_wr_data;
    end

    // Term list. Each move is a sum of +/- edge(a,b) or depot(a) terms.
    // Reverse: head(2) + 2*(j-i) interior + tail(2).
    logic [7:0] s;
    logic [7:0] ri;    // interior index
    logic       last_pos_k, last_pos_j;
    assign s = step_reg;
    assign last_pos_j = ({1'b0, j} + 7'd1) >= len;
    assign last_pos_k = ({1'b0, k} + 7'd1) >= len;
    assign ri = s - 8'd2;

    always_comb
    begin
        tk = TK_NONE;
        tneg = 1'b0;
        pa = '0;
        pb = '0;
        // Head terms, common to all moves: into position i now from node j.
        if (s == 8'd0)
        begin
            tk = (i == 6'd0) ? TK_DEPOT : TK_EDGE;
            pa = (i == 6'd0) ? j : i - 6'd1;
            pb = j;
        end
        else if (s == 8'd1)
        begin
            tneg = 1'b1;
            tk = (i == 6'd0) ? TK_DEPOT : TK_EDGE;
            pa = (i == 6'd0) ? 6'd0 : i - 6'd1;
            pb = i;
        end
        else
        begin
            case (op_t'(req_reg.op))
                OP_REVERSE:
                begin
                    if (ri[7:1] < {1'b0, j - i})
                    begin
                        tk = TK_EDGE;
                        tneg = ri[0];
                        pa = i + ri[6:1] + (ri[0] ? 6'd0 : 6'd1);
                        pb = i + ri[6:1] + (ri[0] ? 6'd1 : 6'd0);
                    end
                    else
                    begin
                        tk = last_pos_j ? TK_DEPOT : TK_EDGE;
                        tneg = ri[0];
                        pa = ri[0] ? j : i;
                        pb = j + 6'd1;
                    end
                end
                OP_SWAP:
                begin
                    if (j == i + 6'd1)
                    begin
                        case (ri)
                            8'd0: begin tk = TK_EDGE; pa = j; pb = i; end
                            8'd1: begin tk = TK_EDGE; tneg = 1'b1; pa = i; pb = j; end
                            8'd2: begin tk = last_pos_j ? TK_DEPOT : TK_EDGE;
                                        pa = i; pb = j + 6'd1; end
                            default: begin tk = last_pos_j ? TK_DEPOT : TK_EDGE;
                                        tneg = 1'b1; pa = j; pb = j + 6'd1; end
                        endcase
                    end
                    else
                    begin
                        case (ri)
                            8'd0: begin tk = TK_EDGE; pa = j; pb = i + 6'd1; end
                            8'd1: begin tk = TK_EDGE; tneg = 1'b1;
                                        pa = j - 6'd1; pb = j; end
                            8'd2: begin tk = TK_EDGE; pa = j - 6'd1; pb = i; end
                            8'd3: begin tk = TK_EDGE; tneg = 1'b1;
                                        pa = i; pb = i + 6'd1; end
                            8'd4: begin tk = last_pos_j ? TK_DEPOT : TK_EDGE;
                                        pa = i; pb = j + 6'd1; end
                            default: begin tk = last_pos_j ? TK_DEPOT : TK_EDGE;
                                        tneg = 1'b1; pa = j; pb = j + 6'd1; end
                        endcase
                    end
                end
                default:
                begin
                    // Rotate.
                    case (ri)
                        8'd0: begin tk = TK_EDGE; tneg = 1'b1;
                                    pa = j - 6'd1; pb = j; end
                        8'd1: begin tk = last_pos_k ? TK_DEPOT : TK_EDGE;
                                    pa = j - 6'd1; pb = k + 6'd1; end
                        8'd2: begin tk = last_pos_k ? TK_DEPOT : TK_EDGE;
                                    tneg = 1'b1; pa = k; pb = k + 6'd1; end
                        default: begin tk = TK_EDGE; pa = k; pb = i; end
                    endcase
                end
            endcase
        end
    end

    // Decode of the request: bad flag and term count.
    logic       len_ok, bad_now;
    logic [7:0] nsteps_now;
    in_item_t   inq;
    assign inq = in_item;
    always_comb
    begin
        len_ok = (len >= 7'd2) && (len <= 7'd64);
        bad_now = !len_ok || (inq.pos_i >= inq.pos_j) || ({1'b0, inq.pos_j} >= len);
        if (op_t'(inq.op) == OP_ROTATE)
            bad_now = bad_now || (inq.pos_j > inq.pos_k) || ({1'b0, inq.pos_k} >= len);
        case (op_t'(inq.op))
            OP_REVERSE: nsteps_now = {1'b0, (inq.pos_j - inq.pos_i), 1'b0} + 8'd4;
            OP_SWAP:    nsteps_now = (inq.pos_j == inq.pos_i + 6'd1) ? 8'd6 : 8'd8;
            default:    nsteps_now = 8'd6;
        endcase
    end

    // Reverse tail: step 2*(j-i)+2 is +tail from node i, +3 is -tail from node j.
    // The branch above picks pa by ri[0]: even -> i, odd -> j.

    // Store write side.
    assign tour_we  = accept && op_t'(in_item.op) == OP_WR_TOUR;
    assign time_we  = accept && op_t'(in_item.op) == OP_WR_TIME
                      && (int'(in_item.from_node) < NODE_COUNT)
                      && (int'(in_item.to_node) < NODE_COUNT);
    assign depot_we = accept && op_t'(in_item.op) == OP_WR_DEPOT
                      && (int'(in_item.from_node) < NODE_COUNT);

    logic [NB-1:0] wr_from, wr_to;
    assign wr_from = NB'(in_item.from_node);
    assign wr_to   = NB'(in_item.to_node);

    assign tour_rd_addr = phase_reg ? pb : pa;

    // Node range check: tour holds 6-bit nodes; beyond NODE_COUNT reads 0.
    logic [5:0] node_a_raw_reg, node_b_raw_reg;
    logic       range_ok;
    assign range_ok = (int'(node_a_raw_reg) < NODE_COUNT)
                      && (int'(node_b_raw_reg) < NODE_COUNT || tk == TK_DEPOT);
    // Issue the time read in TIME straight from the tour data, so it lands in ACC.
    assign time_rd_addr = {na_reg, (state_reg == ST_TIME) ? NB'(tour_rd_data) : nb_reg};

    tmd_ram #(.WIDTH(6), .DEPTH(64)) u_tour (
        .clk(clk), .wr_en(tour_we), .wr_addr(in_item.pos_i),
        .wr_data(in_item.from_node), .rd_addr(tour_rd_addr), .rd_data(tour_rd_data)
    );
    tmd_ram #(.WIDTH(TIME_BITS), .DEPTH(1 << TA)) u_time (
        .clk(clk), .wr_en(time_we), .wr_addr({wr_from, wr_to}),
        .wr_data(TIME_BITS'(in_item.time_value)), .rd_addr(time_rd_addr),
        .rd_data(time_rd_data)
    );
    tmd_ram #(.WIDTH(TIME_BITS), .DEPTH(NODE_COUNT)) u_depot (
        .clk(clk), .wr_en(depot_we), .wr_addr(wr_from),
        .wr_data(TIME_BITS'(in_item.time_value)), .rd_addr(na_reg),
        .rd_data(depot_rd_data)
    );

    // Sequencer: TOUR issues read of a, NODE latches a and issues b,
    // TIME latches b and issues time read, ACC adds the term.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = (op_t'(in_item.op) == OP_REVERSE
                                  || op_t'(in_item.op) == OP_SWAP
                                  || op_t'(in_item.op) == OP_ROTATE) && !bad_now
                                 ? ST_TOUR : ST_OUT;
            ST_TOUR: state_next = ST_NODE;
            ST_NODE: state_next = ST_TIME;
            ST_TIME: state_next = ST_ACC;
            ST_ACC:  state_next = (step_reg + 8'd1 == nsteps_reg) ? ST_OUT : ST_TOUR;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    logic signed [SB-1:0] term;
    logic [TIME_BITS-1:0] mag;
    always_comb
    begin
        mag = (tk == TK_DEPOT) ? depot_rd_data : time_rd_data;
        if (!range_ok || tk == TK_NONE)
            mag = '0;
        term = tneg ? -SB'(mag) : SB'(mag);
        acc_next = acc_reg + 64'(term);
        step_next = step_reg + 8'd1;
    end

    // Saturate to 40 bits.
    logic signed [39:0] sat;
    always_comb
    begin
        if (acc_reg > 64'sh0000_007F_FFFF_FFFF)
            sat = 40'sh7F_FFFF_FFFF;
        else if (acc_reg < -64'sh0000_0080_0000_0000)
            sat = -40'sh80_0000_0000;
        else
            sat = acc_reg[39:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= (state_next == ST_NODE);
            if (state_reg == ST_OUT)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= in_item;
            acc_reg <= '0;
            step_reg <= '0;
            nsteps_reg <= nsteps_now;
            bad_reg <= (op_t'(in_item.op) == OP_REVERSE || op_t'(in_item.op) == OP_SWAP
                        || op_t'(in_item.op) == OP_ROTATE) && bad_now;
        end
        if (state_reg == ST_NODE)
            node_a_raw_reg <= tour_rd_data;
        if (state_reg == ST_TIME)
            node_b_raw_reg <= tour_rd_data;
        if (state_reg == ST_ACC)
        begin
            acc_reg <= acc_next;
            step_reg <= step_next;
        end
        if (state_reg == ST_OUT)
        begin
            out_reg.delta <= bad_reg ? '0 : sat;
            out_reg.bad_request <= bad_reg;
        end
    end

    // Node registers for the time/depot address.
    assign na_reg = NB'(node_a_raw_reg);
    assign nb_reg = NB'(node_b_raw_reg);

    assign out_valid = out_valid_reg;
    assign out_item = out_reg;

endmodule
`default_nettype wire

// File: design/tmd_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module tmd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]              rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire
